// ----- rtl/rlcfd_pkg.sv -----
// Package for the RGB LED chain frame driver.
// Holds chain size, field widths, item opcodes and frame byte constants.
// No dependencies.
`default_nettype none

package rlcfd_pkg;

    localparam int LED_COUNT   = 3;
    localparam int LED_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int START_BYTES = 4;
    localparam int END_BYTES   = 4;

    localparam int OPCODE_W    = 2;
    localparam int BYTE_W      = 8;
    localparam int BRIGHT_W    = 5;
    localparam int COLOUR_W    = 3 * BYTE_W;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [OPCODE_W-1:0] OP_SAMPLE    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_COLOUR_SW = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LED_SW    = 2'd2;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [BYTE_W-1:0]   HEADER_MARK     = 8'hE0;
    localparam logic [BYTE_W-1:0]   START_BYTE      = 8'h00;
    localparam logic [BYTE_W-1:0]   END_BYTE        = 8'hFF;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET    = 5'd1;
    localparam logic                REG_BRIGHTNESS  = 1'b0;

endpackage

`default_nettype wire

// ----- rtl/rgb_led_chain_frame_driver.sv -----
// RGB LED chain frame driver: colour store, selection state and frame sequencer; uses rlcfd_pkg.
// Switch-edge items are taken with no output; ready stays high.
// A sample item updates the colour store in the write state, then emits 4 + 4*LED_COUNT + 4
// bytes (20 for three LEDs), one per cycle while the sink is ready.
// Input ready stays low from a sample item until its frame's last byte is registered for output.
// Reset clears all colours, selections and toggles and sets brightness to 1.
`default_nettype none

module rgb_led_chain_frame_driver (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [rlcfd_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] sample_value
    input  wire  [rlcfd_pkg::OPCODE_W-1:0]    s_tuser,   // [1:0] opcode
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [rlcfd_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] spi_byte
    output logic                              m_tlast,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [rlcfd_pkg::PADDR_W-1:0]     paddr,
    input  wire  [rlcfd_pkg::PDATA_W-1:0]     pwdata,
    output logic [rlcfd_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    import rlcfd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WRITE, ST_EMIT} state_t;
    typedef enum logic [1:0] {PH_START, PH_LED, PH_END} phase_t;

    state_t                state_reg,      state_next;
    phase_t                phase_reg,      phase_next;
    logic [1:0]            sub_reg,        sub_next;
    logic [LED_W-1:0]      led_cnt_reg,    led_cnt_next;
    logic [LED_W-1:0]      sel_led_reg,    sel_led_next;
    logic [1:0]            sel_ch_reg,     sel_ch_next;
    logic                  ch_tog_reg,     ch_tog_next;
    logic                  led_tog_reg,    led_tog_next;
    logic [BYTE_W-1:0]     sample_reg,     sample_next;
    logic [BRIGHT_W-1:0]   bright_reg,     bright_next;
    logic [COLOUR_W-1:0]   colours_reg [LED_COUNT];
    logic [COLOUR_W-1:0]   colours_next [LED_COUNT];
    logic                  m_tvalid_reg,   m_tvalid_next;
    logic [BYTE_W-1:0]     m_tdata_reg,    m_tdata_next;
    logic                  m_tlast_reg,    m_tlast_next;

    logic                  in_accept;
    logic                  slot_free;
    logic                  cfg_write;
    logic [COLOUR_W-1:0]   led_word;
    logic [BYTE_W-1:0]     sel_byte;
    logic                  led_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign led_last  = (led_cnt_reg == LED_W'(LED_COUNT - 1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_BRIGHTNESS)
                    ? {{(PDATA_W-BRIGHT_W){1'b0}}, bright_reg} : '0;

    // Shared byte selector for the LED slot.
    assign led_word = colours_reg[led_cnt_reg];
    always_comb
    begin
        case (sub_reg)
            2'd0:    sel_byte = HEADER_MARK | {{(BYTE_W-BRIGHT_W){1'b0}}, bright_reg};
            2'd1:    sel_byte = led_word[7:0];
            2'd2:    sel_byte = led_word[15:8];
            default: sel_byte = led_word[23:16];
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        sub_next      = sub_reg;
        led_cnt_next  = led_cnt_reg;
        sel_led_next  = sel_led_reg;
        sel_ch_next   = sel_ch_reg;
        ch_tog_next   = ch_tog_reg;
        led_tog_next  = led_tog_reg;
        sample_next   = sample_reg;
        bright_next   = bright_reg;
        colours_next  = colours_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (cfg_write && paddr[2] == REG_BRIGHTNESS)
        begin
            bright_next = pwdata[BRIGHT_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (s_tuser)
                        OP_SAMPLE:
                        begin
                            sample_next = s_tdata;
                            state_next  = ST_WRITE;
                        end
                        OP_COLOUR_SW:
                        begin
                            ch_tog_next = !ch_tog_reg;
                            if (!ch_tog_reg)
                            begin
                                sel_ch_next = (sel_ch_reg == CH_BLUE) ? CH_RED
                                                                      : sel_ch_reg + 2'd1;
                            end
                        end
                        OP_LED_SW:
                        begin
                            led_tog_next = !led_tog_reg;
                            if (!led_tog_reg)
                            begin
                                sel_led_next = (sel_led_reg == LED_W'(LED_COUNT - 1))
                                             ? '0 : sel_led_reg + LED_W'(1);
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                case (sel_ch_reg)
                    CH_RED:   colours_next[sel_led_reg][23:16] = sample_reg;
                    CH_GREEN: colours_next[sel_led_reg][15:8]  = sample_reg;
                    CH_BLUE:  colours_next[sel_led_reg][7:0]   = sample_reg;
                    default:  colours_next[sel_led_reg]        = colours_reg[sel_led_reg];
                endcase
                phase_next   = PH_START;
                sub_next     = 2'd0;
                led_cnt_next = '0;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b0;
                    sub_next      = sub_reg + 2'd1;
                    case (phase_reg)
                        PH_START:
                        begin
                            m_tdata_next = START_BYTE;
                            if (sub_reg == 2'(START_BYTES - 1))
                            begin
                                phase_next = PH_LED;
                            end
                        end
                        PH_LED:
                        begin
                            m_tdata_next = sel_byte;
                            if (sub_reg == 2'd3)
                            begin
                                if (led_last)
                                begin
                                    led_cnt_next = '0;
                                    phase_next   = PH_END;
                                end
                                else
                                begin
                                    led_cnt_next = led_cnt_reg + LED_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            m_tdata_next = END_BYTE;
                            if (sub_reg == 2'(END_BYTES - 1))
                            begin
                                m_tlast_next = 1'b1;
                                state_next   = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_START;
            sub_reg      <= 2'd0;
            led_cnt_reg  <= '0;
            sel_led_reg  <= '0;
            sel_ch_reg   <= CH_RED;
            ch_tog_reg   <= 1'b0;
            led_tog_reg  <= 1'b0;
            sample_reg   <= '0;
            bright_reg   <= BRIGHT_RESET;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                colours_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            sub_reg      <= sub_next;
            led_cnt_reg  <= led_cnt_next;
            sel_led_reg  <= sel_led_next;
            sel_ch_reg   <= sel_ch_next;
            ch_tog_reg   <= ch_tog_next;
            led_tog_reg  <= led_tog_next;
            sample_reg   <= sample_next;
            bright_reg   <= bright_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tlast_reg  <= m_tlast_next;
            colours_reg  <= colours_next;
        end
    end

    a_last_is_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == END_BYTE)
        else $error("last byte is not an end byte");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        sel_ch_reg == CH_RED || sel_ch_reg == CH_GREEN || sel_ch_reg == CH_BLUE)
        else $error("channel selection out of range");

    a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
        sel_led_reg <= LED_W'(LED_COUNT - 1))
        else $error("LED selection out of range");

    a_write_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |=> state_reg == ST_EMIT && phase_reg == PH_START)
        else $error("store update not followed by frame start");

    a_led_phase_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && phase_reg == PH_LED |-> led_cnt_reg <= LED_W'(LED_COUNT - 1))
        else $error("LED slot index out of range");

endmodule

`default_nettype wire

// ----- verif/rgb_led_chain_frame_driver_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the RGB LED chain frame driver: drives stream items
// and APB brightness writes, predicts every frame byte and compares it on the output.
// Depends on rlcfd_pkg and rgb_led_chain_frame_driver.

module rgb_led_chain_frame_driver_tb;

    import rlcfd_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED       = 2'd3;
    localparam logic [PADDR_W-1:0]  ADDR_BRIGHTNESS = PADDR_W'(4 * REG_BRIGHTNESS);
    localparam int                  SETTLE_CYCLES   = 30;
    localparam int                  STALL_PCT       = 38;
    localparam int                  MAX_REPORTS     = 10;

    typedef struct packed
    {
        logic [BYTE_W-1:0] spi_byte;
        logic              frame_last;
    } frame_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;   // [7:0] sample_value
    logic [OPCODE_W-1:0]   s_tuser;   // [1:0] opcode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [BYTE_W-1:0]     m_tdata;   // [7:0] spi_byte
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // shadow of the block's colour store, selections and brightness
    logic [COLOUR_W-1:0]   led_rgb [LED_COUNT];
    logic [LED_W-1:0]      sel_led;
    logic [1:0]            sel_channel;
    logic                  colour_toggle;
    logic                  led_toggle;
    logic [BRIGHT_W-1:0]   brightness;

    frame_byte_t           frame_bytes_due [$];
    bit                    stall_en;
    int                    mismatch_count;
    int                    bytes_checked;
    int                    frames_sent;
    int                    switch_edges;
    int                    brightness_writes;

    rgb_led_chain_frame_driver u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("timeout with %0d frame bytes outstanding", frame_bytes_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void push_frame_byte(logic [BYTE_W-1:0] value, logic last);
        frame_byte_t fb;
        fb.spi_byte   = value;
        fb.frame_last = last;
        frame_bytes_due.push_back(fb);
    endfunction

    // Update the shadow state for one accepted item and, for a sample item, queue the frame it causes.
    function automatic void apply_led_item(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] sample);
        case (op)
            OP_COLOUR_SW:
            begin
                switch_edges++;
                colour_toggle = ~colour_toggle;
                if (colour_toggle)
                    sel_channel = (sel_channel == CH_BLUE) ? CH_RED : sel_channel + 2'd1;
            end
            OP_LED_SW:
            begin
                switch_edges++;
                led_toggle = ~led_toggle;
                if (led_toggle)
                    sel_led = (sel_led == LED_W'(LED_COUNT - 1)) ? '0 : sel_led + 1'b1;
            end
            OP_SAMPLE:
            begin
                frames_sent++;
                case (sel_channel)
                    CH_RED:   led_rgb[sel_led][23:16] = sample;
                    CH_GREEN: led_rgb[sel_led][15:8]  = sample;
                    CH_BLUE:  led_rgb[sel_led][7:0]   = sample;
                    default:  ;
                endcase
                for (int i = 0; i < START_BYTES; i++)
                    push_frame_byte(START_BYTE, 1'b0);
                for (int i = 0; i < LED_COUNT; i++)
                begin
                    push_frame_byte(HEADER_MARK | BYTE_W'(brightness), 1'b0);
                    push_frame_byte(led_rgb[i][7:0], 1'b0);
                    push_frame_byte(led_rgb[i][15:8], 1'b0);
                    push_frame_byte(led_rgb[i][23:16], 1'b0);
                end
                for (int i = 0; i < END_BYTES; i++)
                    push_frame_byte(END_BYTE, i == END_BYTES - 1);
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        frame_byte_t exp_byte;
        if (rst_n && m_tvalid && m_tready)
        begin
            bytes_checked++;
            if (frame_bytes_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%t unexpected frame byte %02h last %0b", $realtime, m_tdata, m_tlast);
            end
            else
            begin
                exp_byte = frame_bytes_due.pop_front();
                if (m_tdata !== exp_byte.spi_byte || m_tlast !== exp_byte.frame_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%t frame byte: expected %02h last %0b, got %02h last %0b",
                                 $realtime, exp_byte.spi_byte, exp_byte.frame_last,
                                 m_tdata, m_tlast);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= stall_en ? ($urandom_range(99) >= STALL_PCT) : 1'b1;
    end

    // Called and returns at a falling edge; leaves tvalid high after the item.
    task automatic send_item(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] sample);
        while (stall_en && $urandom_range(99) < STALL_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= sample;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_led_item(op, sample);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_brightness(logic [PDATA_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_BRIGHTNESS;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        brightness = value[BRIGHT_W-1:0];
        brightness_writes++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_frame();
        send_item(OP_SAMPLE, 8'h00);
    endtask

    task automatic test_selection_and_wrap();
        send_item(OP_SAMPLE, 8'hFF);
        send_item(OP_SAMPLE, 8'h00);
        send_item(OP_COLOUR_SW, 8'h00);
        send_item(OP_SAMPLE, 8'h5A);
        send_item(OP_COLOUR_SW, 8'hFF);
        send_item(OP_SAMPLE, 8'hA5);
        send_item(OP_COLOUR_SW, 8'h00);
        send_item(OP_COLOUR_SW, 8'h00);
        send_item(OP_SAMPLE, 8'hFF);
        send_item(OP_COLOUR_SW, 8'h00);
        send_item(OP_COLOUR_SW, 8'h00);
        send_item(OP_LED_SW, 8'h00);
        send_item(OP_SAMPLE, 8'h81);
        send_item(OP_LED_SW, 8'h00);
        send_item(OP_LED_SW, 8'h00);
        send_item(OP_LED_SW, 8'h00);
        send_item(OP_SAMPLE, 8'h7E);
        send_item(OP_LED_SW, 8'h00);
        send_item(OP_LED_SW, 8'h00);
        send_item(OP_SAMPLE, 8'h3C);
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_SAMPLE, 8'h01);
    endtask

    task automatic test_brightness_extremes();
        write_brightness('0);
        send_item(OP_SAMPLE, 8'h42);
        write_brightness(PDATA_W'(31));
        send_item(OP_SAMPLE, 8'hC3);
        // upper bits set; only the low five count
        write_brightness({{(PDATA_W - BRIGHT_W){1'b1}}, 5'h0A});
        send_item(OP_SAMPLE, 8'h99);
    endtask

    task automatic test_random_mix(int phases, int items_per_phase);
        int r;
        for (int p = 0; p < phases; p++)
        begin
            case (p)
                0:       write_brightness(PDATA_W'($urandom) | PDATA_W'(5'h1F));
                1:       write_brightness({PDATA_W'($urandom)} & ~PDATA_W'(5'h1F));
                default: write_brightness(PDATA_W'($urandom));
            endcase
            for (int i = 0; i < items_per_phase; i++)
            begin
                r = $urandom_range(99);
                if (r < 45)
                    send_item(OP_SAMPLE, pick_sample());
                else if (r < 70)
                    send_item(OP_COLOUR_SW, BYTE_W'($urandom));
                else if (r < 92)
                    send_item(OP_LED_SW, BYTE_W'($urandom));
                else
                    send_item(OP_UNUSED, BYTE_W'($urandom));
            end
        end
    endtask

    task automatic test_back_to_back();
        stall_en = 1'b0;
        test_random_mix(1, 30);
        stall_en = 1'b1;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_SAMPLE;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        stall_en    = 1'b1;
        for (int i = 0; i < LED_COUNT; i++)
            led_rgb[i] = '0;
        sel_led       = '0;
        sel_channel   = CH_RED;
        colour_toggle = 1'b0;
        led_toggle    = 1'b0;
        brightness    = BRIGHT_RESET;
        mismatch_count    = 0;
        bytes_checked     = 0;
        frames_sent       = 0;
        switch_edges      = 0;
        brightness_writes = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_frame();
        test_selection_and_wrap();
        test_brightness_extremes();
        test_random_mix(4, 32);
        test_back_to_back();

        wait_idle();

        if (frame_bytes_due.size() != 0)
            mismatch_count += frame_bytes_due.size();
        $display("covered %0d frames, %0d frame bytes checked, %0d switch edges,",
                 frames_sent, bytes_checked, switch_edges);
        $display("and %0d brightness writes; %0d mismatches", brightness_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rlcfd_pkg.sv
rtl/rgb_led_chain_frame_driver.sv
verif/rgb_led_chain_frame_driver_tb.sv
